/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/swdhte_pkg.sv */
// ----------------------------------------------------------------------------
// SWD host transaction engine package
// Payload types, protocol codes, phases and the request header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package swdhte_pkg;

	// Command codes carried in the opcode field.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_TSEL  = 2'd3
	} opcode_t;

	// Transaction status codes.
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FAULT  = 2'd1,
		STAT_PROTO  = 2'd2,
		STAT_PARITY = 2'd3
	} status_t;

	// Transaction phases.
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_REQ   = 4'd1,
		PH_TRN   = 4'd2,
		PH_ACK   = 4'd3,
		PH_RDATA = 4'd4,
		PH_RPAR  = 4'd5,
		PH_RTURN = 4'd6,
		PH_TURN  = 4'd7,
		PH_WDATA = 4'd8,
		PH_WPAR  = 4'd9
	} phase_t;

	// Acknowledge codes as received, first bit in bit 0.
	localparam logic [2:0] ACK_OK    = 3'b001;
	localparam logic [2:0] ACK_WAIT  = 3'b010;
	localparam logic [2:0] ACK_FAULT = 3'b100;

	// Fixed header sent for target select.
	localparam logic [7:0] TSEL_HEADER = 8'h99;

	// Bit counts of the request, acknowledge and data fields.
	localparam logic [5:0] REQ_BITS  = 6'd8;
	localparam logic [5:0] ACK_BITS  = 6'd3;
	localparam logic [5:0] DATA_BITS = 6'd32;

	typedef struct packed {
		opcode_t     opcode;
		logic        ap_not_dp;
		logic [1:0]  reg_addr;
		logic [31:0] write_data;
		logic        line_in;
	} swd_in_t;

	typedef struct packed {
		logic        line_out;
		logic        line_drive;
		logic        busy_res;
		logic        done_res;
		status_t     status;
		logic [31:0] read_data;
	} swd_out_t;

	// Request byte, sent LSB first: start, APnDP, RnW, A2, A3, parity, stop, park.
	function automatic logic [7:0] build_request(opcode_t cmd, logic ap, logic [1:0] addr);
		logic rnw;
		logic par;
		rnw = (cmd == OP_READ);
		par = ap ^ rnw ^ addr[0] ^ addr[1];
		if (cmd == OP_TSEL) begin
			build_request = TSEL_HEADER;
		end else begin
			build_request = {1'b1, 1'b0, par, addr[1], addr[0], rnw, ap, 1'b1};
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/swd_host_transaction_engine.sv */
// ----------------------------------------------------------------------------
// SWD host transaction engine
// Steps a Serial Wire Debug read, write or target-select transaction by one
// SWD clock period for every input transaction.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on in_valid/in_ready is one SWD clock period. It
// carries a command (taken only while the engine is idle), the request fields,
// the write word and the data line level sampled in that period.
// For every input transaction exactly one output transaction appears on
// out_valid/out_ready: the line level and drive enable for that period, busy,
// done, status and, at the end of a read, the word read.
// The result is registered at the edge that accepts the input. Throughput is
// one period per cycle while the receiver does not stall, set by the single
// state update between the phase register and the result register.
// When the receiver stalls, the result holds in the output register and a new
// input is taken in the same cycle that the held result is taken.
// Reset returns the engine to idle with all held fields cleared and no result
// pending. Idle periods drive the line low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swd_host_transaction_engine
	import swdhte_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire swd_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output swd_out_t      out_data
);

	// Engine state.
	phase_t      phase_q;
	logic [5:0]  count_q;
	logic [31:0] shift_q;
	logic [2:0]  ack_q;
	opcode_t     cmd_q;
	logic        port_q;
	logic [1:0]  addr_q;
	logic [31:0] wword_q;
	logic        par_q;

	// Output register.
	logic        out_valid_q;
	swd_out_t    out_data_q;

	// Values after a command is captured in an idle period.
	phase_t      phase_e;
	logic [5:0]  count_e;
	logic [31:0] shift_e;
	opcode_t     cmd_e;
	logic        port_e;
	logic [1:0]  addr_e;
	logic [31:0] wword_e;

	// Next state.
	phase_t      phase_d;
	logic [5:0]  count_d;
	logic [31:0] shift_d;
	logic [2:0]  ack_d;
	logic        par_d;
	logic [5:0]  count_inc;
	logic [2:0]  ack_sampled;

	swd_out_t    res;
	logic        in_fire;
	logic        sample;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign sample   = in_data.line_in;

	// A command is taken only while idle; its start bit goes out in the same period.
	always_comb begin
		phase_e = phase_q;
		count_e = count_q;
		shift_e = shift_q;
		cmd_e   = cmd_q;
		port_e  = port_q;
		addr_e  = addr_q;
		wword_e = wword_q;
		if (phase_q == PH_IDLE && in_data.opcode != OP_TICK) begin
			cmd_e   = in_data.opcode;
			port_e  = in_data.ap_not_dp;
			addr_e  = in_data.reg_addr;
			wword_e = in_data.write_data;
			shift_e = {24'd0, build_request(in_data.opcode, in_data.ap_not_dp,
				in_data.reg_addr)};
			count_e = 6'd0;
			phase_e = PH_REQ;
		end
	end

	assign count_inc   = count_e + 6'd1;
	assign ack_sampled = ack_q | (3'(sample) << count_e[1:0]);

	// Next-state logic.
	always_comb begin
		phase_d = phase_e;
		count_d = count_e;
		shift_d = shift_e;
		ack_d   = ack_q;
		par_d   = par_q;
		unique case (phase_e)
			PH_IDLE: begin
			end
			PH_REQ: begin
				shift_d = {1'b0, shift_e[31:1]};
				count_d = count_inc;
				if (count_inc >= REQ_BITS) begin
					count_d = 6'd0;
					phase_d = PH_TRN;
				end
			end
			PH_TRN: begin
				ack_d   = 3'd0;
				count_d = 6'd0;
				phase_d = PH_ACK;
			end
			PH_ACK: begin
				ack_d   = ack_sampled;
				count_d = count_inc;
				if (count_inc >= ACK_BITS) begin
					count_d = 6'd0;
					if (cmd_e == OP_READ && ack_sampled == ACK_OK) begin
						shift_d = 32'd0;
						par_d   = 1'b0;
						phase_d = PH_RDATA;
					end else begin
						phase_d = PH_TURN;
					end
				end
			end
			PH_RDATA: begin
				shift_d = {sample, shift_e[31:1]};
				par_d   = par_q ^ sample;
				count_d = count_inc;
				if (count_inc >= DATA_BITS) begin
					count_d = 6'd0;
					phase_d = PH_RPAR;
				end
			end
			PH_RPAR: begin
				par_d   = par_q ^ sample;
				phase_d = PH_RTURN;
			end
			PH_RTURN: begin
				phase_d = PH_IDLE;
			end
			PH_TURN: begin
				if (cmd_e == OP_TSEL || ack_q == ACK_OK) begin
					shift_d = wword_e;
					par_d   = 1'b0;
					count_d = 6'd0;
					phase_d = PH_WDATA;
				end else if (ack_q == ACK_WAIT) begin
					shift_d = {24'd0, build_request(cmd_e, port_e, addr_e)};
					count_d = 6'd0;
					phase_d = PH_REQ;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WDATA: begin
				par_d   = par_q ^ shift_e[0];
				shift_d = {1'b0, shift_e[31:1]};
				count_d = count_inc;
				if (count_inc >= DATA_BITS) begin
					count_d = 6'd0;
					phase_d = PH_WPAR;
				end
			end
			PH_WPAR: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (phase_d == PH_IDLE) begin
			count_d = 6'd0;
		end
	end

	// Result for this period.
	always_comb begin
		res            = '0;
		res.status     = STAT_OK;
		res.busy_res   = (phase_d != PH_IDLE);
		unique case (phase_e)
			PH_IDLE: begin
				res.line_drive = 1'b1;
			end
			PH_REQ, PH_WDATA: begin
				res.line_drive = 1'b1;
				res.line_out   = shift_e[0];
			end
			PH_TRN, PH_ACK, PH_RDATA, PH_RPAR: begin
			end
			PH_RTURN: begin
				res.done_res = 1'b1;
				if (par_q) begin
					res.status = STAT_PARITY;
				end else begin
					res.read_data = shift_e;
				end
			end
			PH_TURN: begin
				if (!(cmd_e == OP_TSEL || ack_q == ACK_OK) && ack_q != ACK_WAIT) begin
					res.done_res = 1'b1;
					res.status   = (ack_q == ACK_FAULT) ? STAT_FAULT : STAT_PROTO;
				end
			end
			PH_WPAR: begin
				res.line_drive = 1'b1;
				res.line_out   = par_q;
				res.done_res   = 1'b1;
			end
			default: begin
				res.line_drive = 1'b1;
			end
		endcase
	end

	// State registers advance once per accepted period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= 6'd0;
			shift_q <= 32'd0;
			ack_q   <= 3'd0;
			cmd_q   <= OP_TICK;
			port_q  <= 1'b0;
			addr_q  <= 2'd0;
			wword_q <= 32'd0;
			par_q   <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			ack_q   <= ack_d;
			cmd_q   <= cmd_e;
			port_q  <= port_e;
			addr_q  <= addr_e;
			wword_q <= wword_e;
			par_q   <= par_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Assertions.
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> phase_q == PH_IDLE, "engine not idle after reset")
	`ASSERT_CLKD(a_done_not_busy, clk, arst_n, out_valid_q && out_data_q.done_res |-> !out_data_q.busy_res, "done period still reports busy")
	`ASSERT_CLKD(a_status_needs_done, clk, arst_n, out_valid_q && out_data_q.status != STAT_OK |-> out_data_q.done_res, "status without done")
	`ASSERT_CLKD(a_idle_drives, clk, arst_n, in_fire && phase_q == PH_IDLE |=> out_data_q.line_drive, "line released in an idle period")
	`ASSERT_CLKD(a_busy_tracks_phase, clk, arst_n, in_fire |=> out_data_q.busy_res == (phase_q != PH_IDLE), "busy does not match phase")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// SWD host transaction engine testbench
// Plays the target side of the wire period by period: well-formed read, write
// and target-select exchanges with chosen acknowledges, WAIT retries, read
// data and parity, plus some noisy ones. A scoreboard predicts every period's
// output and compares it with what the engine returns. Both handshakes idle
// and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import swdhte_pkg::*;

	// Plan of one transaction as the emulated target will answer it.
	typedef struct {
		opcode_t     op;
		logic        port;
		logic [1:0]  addr;
		logic [31:0] word;
		int unsigned waits;
		logic [2:0]  last_ack;
		logic [31:0] read_word;
		bit          parity_good;
		bit          noisy;
	} txn_plan_t;

	// Predicts the engine one SWD period at a time and holds the expected outputs.
	class swd_engine_scoreboard;
		phase_t      phase;
		logic [5:0]  bit_cnt;
		logic [31:0] shreg;
		logic [2:0]  ack;
		opcode_t     cmd;
		logic        port;
		logic [1:0]  addr;
		logic [31:0] wword;
		logic        par;
		swd_out_t    expected_periods[$];
		int unsigned errors, checked;
		int unsigned reads_ok, writes_done, tsels_done, retries, faults, protos, par_errs;

		function new();
			phase = PH_IDLE;
			bit_cnt = '0;
			shreg = '0;
			ack = '0;
			cmd = OP_TICK;
			port = 1'b0;
			addr = '0;
			wword = '0;
			par = 1'b0;
		endfunction

		function logic [7:0] request_byte();
			logic rnw;
			rnw = (cmd == OP_READ);
			if (cmd == OP_TSEL) begin
				return TSEL_HEADER;
			end
			return {1'b1, 1'b0, port ^ rnw ^ addr[0] ^ addr[1], addr[1], addr[0], rnw, port, 1'b1};
		endfunction

		function int unsigned pending();
			return expected_periods.size();
		endfunction

		// Advance the prediction by one accepted period.
		function void take_period(swd_in_t it);
			swd_out_t r;
			logic     b;
			r = '0;
			r.status = STAT_OK;
			if (phase == PH_IDLE && it.opcode != OP_TICK) begin
				cmd = it.opcode;
				port = it.ap_not_dp;
				addr = it.reg_addr;
				wword = it.write_data;
				shreg = {24'd0, request_byte()};
				bit_cnt = '0;
				phase = PH_REQ;
			end
			case (phase)
				PH_IDLE: begin
					r.line_drive = 1'b1;
				end
				PH_REQ: begin
					r.line_drive = 1'b1;
					r.line_out = shreg[0];
					shreg = shreg >> 1;
					bit_cnt++;
					if (bit_cnt >= REQ_BITS) begin
						bit_cnt = '0;
						phase = PH_TRN;
					end
				end
				PH_TRN: begin
					ack = '0;
					bit_cnt = '0;
					phase = PH_ACK;
				end
				PH_ACK: begin
					ack = ack | ({2'b00, it.line_in} << bit_cnt[1:0]);
					bit_cnt++;
					if (bit_cnt >= ACK_BITS) begin
						bit_cnt = '0;
						if (cmd == OP_READ && ack == ACK_OK) begin
							shreg = '0;
							par = 1'b0;
							phase = PH_RDATA;
						end else begin
							phase = PH_TURN;
						end
					end
				end
				PH_RDATA: begin
					shreg = {it.line_in, shreg[31:1]};
					par ^= it.line_in;
					bit_cnt++;
					if (bit_cnt >= DATA_BITS) begin
						bit_cnt = '0;
						phase = PH_RPAR;
					end
				end
				PH_RPAR: begin
					par ^= it.line_in;
					phase = PH_RTURN;
				end
				PH_RTURN: begin
					r.done_res = 1'b1;
					if (par) begin
						r.status = STAT_PARITY;
						par_errs++;
					end else begin
						r.read_data = shreg;
						reads_ok++;
					end
					phase = PH_IDLE;
				end
				PH_TURN: begin
					if (cmd == OP_TSEL || ack == ACK_OK) begin
						shreg = wword;
						par = 1'b0;
						bit_cnt = '0;
						phase = PH_WDATA;
					end else if (ack == ACK_WAIT) begin
						shreg = {24'd0, request_byte()};
						bit_cnt = '0;
						phase = PH_REQ;
						retries++;
					end else begin
						r.done_res = 1'b1;
						if (ack == ACK_FAULT) begin
							r.status = STAT_FAULT;
							faults++;
						end else begin
							r.status = STAT_PROTO;
							protos++;
						end
						phase = PH_IDLE;
					end
				end
				PH_WDATA: begin
					b = shreg[0];
					r.line_drive = 1'b1;
					r.line_out = b;
					par ^= b;
					shreg = shreg >> 1;
					bit_cnt++;
					if (bit_cnt >= DATA_BITS) begin
						bit_cnt = '0;
						phase = PH_WPAR;
					end
				end
				PH_WPAR: begin
					r.line_drive = 1'b1;
					r.line_out = par;
					r.done_res = 1'b1;
					if (cmd == OP_TSEL) begin
						tsels_done++;
					end else begin
						writes_done++;
					end
					phase = PH_IDLE;
				end
				default: begin
					phase = PH_IDLE;
					r.line_drive = 1'b1;
				end
			endcase
			if (phase == PH_IDLE) begin
				bit_cnt = '0;
			end
			r.busy_res = (phase != PH_IDLE);
			expected_periods.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one returned period with the oldest prediction.
		function void check_period(swd_out_t got);
			swd_out_t want;
			if (expected_periods.size() == 0) begin
				$error("result with no transaction outstanding: %h", got);
				errors++;
				return;
			end
			want = expected_periods.pop_front();
			checked++;
			compare_field("line_out", want.line_out, got.line_out);
			compare_field("line_drive", want.line_drive, got.line_drive);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("status", want.status, got.status);
			compare_field("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	swd_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	swd_out_t out_data;

	swd_engine_scoreboard sb = new();

	txn_plan_t   directed_q[$];
	txn_plan_t   cur_plan;
	logic [2:0]  ack_now;
	int unsigned waits_left;
	int unsigned txn_count;
	swd_in_t     next_in;
	int unsigned gap;
	int unsigned sent_total;
	bit          drain_pending;
	bit          drain_done;
	int unsigned cycle_cnt;

	swd_host_transaction_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock with a period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] pick_word();
		int unsigned r;
		r = $urandom_range(19);
		case (r)
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	function automatic txn_plan_t random_plan();
		txn_plan_t   p;
		int unsigned r;
		logic [2:0]  bad_acks[5];
		bad_acks = '{3'b000, 3'b011, 3'b101, 3'b110, 3'b111};
		r = $urandom_range(99);
		if (r < 15) begin
			p.op = OP_TICK;
		end else if (r < 55) begin
			p.op = OP_READ;
		end else if (r < 90) begin
			p.op = OP_WRITE;
		end else begin
			p.op = OP_TSEL;
		end
		p.port = $urandom_range(1);
		p.addr = $urandom_range(3);
		p.word = pick_word();
		p.waits = ($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
		r = $urandom_range(99);
		if (r < 70) begin
			p.last_ack = ACK_OK;
		end else if (r < 82) begin
			p.last_ack = ACK_FAULT;
		end else begin
			p.last_ack = bad_acks[$urandom_range(4)];
		end
		p.read_word = pick_word();
		p.parity_good = ($urandom_range(99) < 85);
		p.noisy = ($urandom_range(99) < 8);
		return p;
	endfunction

	function automatic txn_plan_t plan_of(opcode_t op, logic port, logic [1:0] addr,
			logic [31:0] word, int unsigned waits, logic [2:0] last_ack, bit parity_good);
		txn_plan_t p;
		p.op = op;
		p.port = port;
		p.addr = addr;
		p.word = word;
		p.waits = waits;
		p.last_ack = last_ack;
		p.read_word = word;
		p.parity_good = parity_good;
		p.noisy = 1'b0;
		return p;
	endfunction

	// Build the next period as the target would answer it, from the predicted phase.
	function automatic swd_in_t next_period();
		swd_in_t it;
		it.opcode = opcode_t'($urandom_range(3));
		it.ap_not_dp = $urandom_range(1);
		it.reg_addr = $urandom_range(3);
		it.write_data = pick_word();
		it.line_in = $urandom_range(1);
		case (sb.phase)
			PH_IDLE: begin
				if (directed_q.size() > 0) begin
					cur_plan = directed_q.pop_front();
				end else begin
					cur_plan = random_plan();
				end
				it.opcode = cur_plan.op;
				it.ap_not_dp = cur_plan.port;
				it.reg_addr = cur_plan.addr;
				it.write_data = cur_plan.word;
				waits_left = cur_plan.waits;
				if (cur_plan.op != OP_TICK) begin
					txn_count++;
				end
			end
			PH_ACK: begin
				if (sb.bit_cnt == 0) begin
					if (waits_left > 0) begin
						ack_now = ACK_WAIT;
						waits_left--;
					end else begin
						ack_now = cur_plan.last_ack;
					end
				end
				if (!cur_plan.noisy) begin
					it.line_in = ack_now[sb.bit_cnt[1:0]];
				end
			end
			PH_RDATA: begin
				if (!cur_plan.noisy) begin
					it.line_in = cur_plan.read_word[sb.bit_cnt[4:0]];
				end
			end
			PH_RPAR: begin
				if (!cur_plan.noisy) begin
					it.line_in = cur_plan.parity_good ? sb.par : ~sb.par;
				end
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	// Mostly short gaps, a few long ones, and stretches without any.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (((sent_total / 200) % 4) == 2) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Offer periods until count of them have been accepted. Returns right after
	// an acceptance, before anything is assigned in that time step.
	task automatic drive_periods(int unsigned count);
		int unsigned taken;
		taken = 0;
		while (taken < count) begin
			if (drain_pending) begin
				in_valid <= 1'b0;
				if (sb.pending() == 0) begin
					drain_pending = 1'b0;
				end
			end else if (gap > 0) begin
				in_valid <= 1'b0;
				gap--;
			end else begin
				in_valid <= 1'b1;
				in_data <= next_in;
			end
			@(posedge clk);
			if (in_valid && in_ready) begin
				sb.take_period(in_data);
				taken++;
				sent_total++;
				next_in = next_period();
				gap = pick_gap();
				if (!drain_done && sent_total >= 900) begin
					drain_done = 1'b1;
					drain_pending = 1'b1;
				end
			end
		end
	endtask

	// Check every returned period.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_period(out_data);
		end
	end

	// Receiver side: random stalls, one long hold-off, and stretches always ready.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned r;
		bit          long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		cycle_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!long_hold_done && sent_total >= 500) begin
				long_hold_done = 1'b1;
				hold_left = 79;
				out_ready <= 1'b0;
			end else if (((cycle_cnt / 600) % 4) == 1) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 3) begin
					hold_left = $urandom_range(25, 5);
					out_ready <= 1'b0;
				end else begin
					out_ready <= (r < 78);
				end
			end
		end
	end

	// Main sequence: reset, directed transactions, random traffic, drain, verdict.
	initial begin : sender
		gap = 0;
		sent_total = 0;
		txn_count = 0;
		drain_pending = 1'b0;
		drain_done = 1'b0;
		ack_now = ACK_OK;
		waits_left = 0;

		// Directed: extremes of every field, every command and each ending.
		directed_q.push_back(plan_of(OP_TICK, 1'b0, 2'd0, 32'h0000_0000, 0, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_READ, 1'b1, 2'd3, 32'hffff_ffff, 0, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_READ, 1'b0, 2'd0, 32'h8000_0000, 0, ACK_OK, 1'b0));
		directed_q.push_back(plan_of(OP_WRITE, 1'b1, 2'd2, 32'hffff_ffff, 0, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_WRITE, 1'b0, 2'd1, 32'h0000_0000, 2, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_READ, 1'b1, 2'd1, 32'h0000_ffff, 1, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_TSEL, 1'b0, 2'd0, 32'h8000_0000, 0, 3'b111, 1'b1));
		directed_q.push_back(plan_of(OP_READ, 1'b0, 2'd2, 32'h1234_5678, 0, ACK_FAULT, 1'b1));
		directed_q.push_back(plan_of(OP_WRITE, 1'b1, 2'd3, 32'h0000_0001, 0, 3'b111, 1'b1));
		directed_q.push_back(plan_of(OP_READ, 1'b0, 2'd0, 32'h0000_0000, 0, 3'b000, 1'b1));
		directed_q.push_back(plan_of(OP_TSEL, 1'b1, 2'd3, 32'hffff_0000, 0, ACK_OK, 1'b1));
		directed_q.push_back(plan_of(OP_WRITE, 1'b0, 2'd2, 32'hdead_beef, 0, ACK_FAULT, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		next_in = next_period();

		while (directed_q.size() > 0 || sb.phase != PH_IDLE) begin
			drive_periods(1);
		end
		// Random traffic fills the run up to about 1250 periods in all.
		if (sent_total < 1250) begin
			drive_periods(1250 - sent_total);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);

		$display("Run covered %0d periods in %0d transactions, %0d results checked.",
			sent_total, txn_count, sb.checked);
		$display("Ends: %0d reads ok, %0d writes, %0d target selects, %0d WAIT retries,",
			sb.reads_ok, sb.writes_done, sb.tsels_done, sb.retries);
		$display("      %0d faults, %0d protocol errors, %0d parity errors.",
			sb.faults, sb.protos, sb.par_errs);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
